// File: rtl/signed_binary_to_ascii_decimal_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed binary to ASCII decimal converter
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_ASCII_DECIMAL_TOP_DEFINES_SVH
`define SIGNED_BINARY_TO_ASCII_DECIMAL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SBAD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SBAD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define SBAD_ASSERT(label, clk, rst_n, prop, msg)
`define SBAD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

// File: rtl/sbad_pkg.sv
// ----------------------------------------------------------------------------
// sbad_pkg
// Shared types and constants of the signed binary to ASCII decimal converter.
// ----------------------------------------------------------------------------
package sbad_pkg;

  localparam int unsigned BinWidth   = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CntWidth   = $clog2(BinWidth);
  localparam int unsigned DigWidth   = $clog2(NumDigits + 1);
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef struct packed {
    logic                neg;
    logic [BinWidth-1:0] mag;
  } item_t;

endpackage

// File: rtl/sbad_if.sv
// ----------------------------------------------------------------------------
// sbad_if
// Valid/ready channels: signed value in, ASCII characters out.
// ----------------------------------------------------------------------------
interface sbad_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sbad_pkg::BinWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sbad_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

// File: rtl/sbad_queue.sv
// ----------------------------------------------------------------------------
// sbad_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module sbad_queue #(
  parameter int unsigned Depth = sbad_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  sbad_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output sbad_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sbad_pkg::item_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/sbad_front.sv
// ----------------------------------------------------------------------------
// sbad_front
// Accepts values, splits them into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module sbad_front (
  sbad_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output sbad_pkg::item_t  push_item_o
);

  logic [sbad_pkg::BinWidth-1:0] raw;

  assign raw          = in_i.value;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  // magnitude in unsigned arithmetic: the most negative value maps to 2^31
  always_comb begin
    push_item_o.neg = raw[sbad_pkg::BinWidth-1];
    push_item_o.mag = push_item_o.neg ? (~raw + sbad_pkg::BinWidth'(1)) : raw;
  end

endmodule

// File: rtl/sbad_back.sv
// ----------------------------------------------------------------------------
// sbad_back
// Shift-and-add-3 conversion, leading-zero skip and character output.
// ----------------------------------------------------------------------------
`include "signed_binary_to_ascii_decimal_top_defines.svh"

module sbad_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  sbad_pkg::item_t  pop_item_i,
  sbad_out_if.source       out_o
);

  localparam int unsigned BinW = sbad_pkg::BinWidth;
  localparam int unsigned BcdW = sbad_pkg::BcdWidth;
  localparam int unsigned CntW = sbad_pkg::CntWidth;
  localparam int unsigned DigW = sbad_pkg::DigWidth;

  typedef enum logic [1:0] {StIdle, StConv, StSkip, StEmit} state_e;

  state_e          state_q, state_d;
  logic [BinW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DigW-1:0] ndig_q, ndig_d;
  logic            neg_q, neg_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_char_q, out_char_d;
  logic            out_last_q, out_last_d;
  logic [BcdW-1:0] bcd_adj;
  logic [3:0]      top_digit;
  logic            out_free;

  assign pop_ready_o     = (state_q == StIdle);
  assign out_o.valid     = out_valid_q;
  assign out_o.char_byte = out_char_q;
  assign out_o.last_char = out_last_q;
  assign top_digit       = bcd_q[BcdW-1 -: 4];
  assign out_free        = !out_valid_q || out_o.ready;

  always_comb begin
    for (int i = 0; i < sbad_pkg::NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          bin_d   = pop_item_i.mag;
          neg_d   = pop_item_i.neg;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[BinW-1]};
        bin_d = {bin_q[BinW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(BinW - 1)) begin
          ndig_d  = DigW'(sbad_pkg::NumDigits);
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (top_digit == 4'd0 && ndig_q != DigW'(1)) begin
          bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
          ndig_d = ndig_q - DigW'(1);
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            out_char_d = sbad_pkg::CharMinus;
            out_last_d = 1'b0;
            neg_d      = 1'b0;
          end else begin
            out_char_d = sbad_pkg::CharZero + {4'd0, top_digit};
            out_last_d = (ndig_q == DigW'(1));
            bcd_d      = {bcd_q[BcdW-5:0], 4'd0};
            ndig_d     = ndig_q - DigW'(1);
            if (ndig_q == DigW'(1)) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      bin_q       <= '0;
      bcd_q       <= '0;
      cnt_q       <= '0;
      ndig_q      <= '0;
      neg_q       <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bin_q       <= bin_d;
      bcd_q       <= bcd_d;
      cnt_q       <= cnt_d;
      ndig_q      <= ndig_d;
      neg_q       <= neg_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
    end
  end

  `SBAD_ASSERT(a_char_legal, clk_i, rst_ni, !out_valid_q || out_char_q == sbad_pkg::CharMinus || (out_char_q >= sbad_pkg::CharZero && out_char_q <= sbad_pkg::CharNine), "illegal character")
  `SBAD_ASSERT(a_minus_not_last, clk_i, rst_ni, !(out_valid_q && out_char_q == sbad_pkg::CharMinus && out_last_q), "minus sign flagged last")
  `SBAD_ASSERT_NEXT(a_conv_len, clk_i, rst_ni, state_q == StConv && cnt_q == CntW'(BinW - 1), state_q == StSkip, "conversion length wrong")
  `SBAD_ASSERT(a_digits_left, clk_i, rst_ni, !(state_q == StEmit || state_q == StSkip) || ndig_q != '0, "no digits left to emit")

endmodule

// File: rtl/signed_binary_to_ascii_decimal_top.sv
// Flow: a value passes through the queue, the shift-and-add-3 conversion, the
//   leading-zero skip and the output register before its first character is
//   valid; then one character per cycle, up to 11, while the receiver is ready.
// Pacing: the back end takes no new value until the last character of the one
//   before is in the output register, after the 32-step loop plus the skip and emit steps; queue holds 2.
// Reset: asynchronous, active low; empties the queue, idles the back end and
//   drops any pending character.
// ----------------------------------------------------------------------------
// signed_binary_to_ascii_decimal_top
// Signed 32-bit integer to ASCII decimal text, one character per transaction.
// ----------------------------------------------------------------------------
module signed_binary_to_ascii_decimal_top #(
  parameter int unsigned QueueDepth = sbad_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbad_in_if.sink    in_i,
  sbad_out_if.source out_o
);

  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;
  sbad_pkg::item_t push_item, pop_item;

  sbad_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  sbad_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  sbad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the signed binary to ASCII decimal converter. A short stimulus table
// covers zero, the extremes and the digit-count boundaries. Random values
// follow, with the sender idling and the receiver stalling in several phases.
// Every character transaction is compared, field by field, with the text of the
// table row or, if that is empty, of a local decimal formatter, for each accepted value.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } dec_char_t;

  typedef struct {
    logic [31:0] value;
    string       text;
  } dec_row_t;

  localparam int NumRows     = 20;
  localparam int ItemsPerPhase = 83;

  logic clk_i;
  logic rst_ni;

  sbad_in_if  in_if ();
  sbad_out_if out_if ();

  signed_binary_to_ascii_decimal_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dec_char_t   pending_chars [$];
  int          mismatches;
  int          src_idle_pct;
  int          snk_stall_pct;
  int unsigned pow10 [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
                              100000000, 1000000000};

  // empty text: expectation comes from the formatter
  dec_row_t dec_rows [NumRows] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'hFFFF_FFFF,  "-1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{-32'sd10,       "-10"},
    '{32'd100,        "100"},
    '{-32'sd100,      "-100"},
    '{32'h7FFF_FFFF,  "2147483647"},
    '{32'h8000_0000,  "-2147483648"},
    '{32'h8000_0001,  "-2147483647"},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{-32'sd999999999, "-999999999"},
    '{32'h5555_5555,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'd12345,      ""},
    '{-32'sd67890,    ""},
    '{32'h0000_FFFF,  ""},
    '{32'hFFFF_0000,  ""}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic void format_decimal(input logic [31:0] value);
    logic [31:0] mag;
    logic [7:0]  digs [10];
    int          ndig;
    ndig = 0;
    mag  = value[31] ? -value : value;
    do begin
      digs[ndig] = sbad_pkg::CharZero + 8'(mag % 10);
      mag        = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < 10);
    if (value[31]) pending_chars.push_back('{sbad_pkg::CharMinus, 1'b0});
    for (int k = ndig - 1; k >= 0; k--) pending_chars.push_back('{digs[k], k == 0});
  endfunction

  function automatic void queue_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
    end
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int unsigned p;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = 32'($urandom_range(0, 199)) - 32'd100;
      3: begin
        p = pow10[$urandom_range(0, 9)];
        v = p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      4: v = 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (($urandom_range(0, 2) == 0) && v != 32'h8000_0000) v = -v;
    return v;
  endfunction

  task automatic send_value(input logic [31:0] value, input string text);
    in_if.valid <= 1'b1;
    in_if.value <= value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (text.len() != 0) queue_text(text);
    else format_decimal(value);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.value <= $urandom;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk_i);
    end
  endtask

  // receiver: checks each character transaction and stalls at random
  initial begin
    dec_char_t exp_char;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    out_if.char_byte, out_if.last_char));
        end else begin
          exp_char = pending_chars.pop_front();
          if (out_if.char_byte !== exp_char.char_byte)
            report_mismatch($sformatf("char_byte 0x%02h, expected 0x%02h",
                                      out_if.char_byte, exp_char.char_byte));
          if (out_if.last_char !== exp_char.last_char)
            report_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
                                      out_if.last_char, exp_char.last_char,
                                      exp_char.char_byte));
        end
      end
      out_if.ready <= rst_ni && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  initial begin
    mismatches    = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.value   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) send_value(dec_rows[r].value, dec_rows[r].text);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
        default: begin src_idle_pct = 17; snk_stall_pct = 17; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) send_value(pick_value(), "");
    end
    in_if.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TIMEOUT with %0d chars outstanding", pending_chars.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/sbad_pkg.sv
rtl/sbad_if.sv
rtl/sbad_queue.sv
rtl/sbad_front.sv
rtl/sbad_back.sv
rtl/signed_binary_to_ascii_decimal_top.sv
test/tb_top.sv
